// File: hw/rtl/assert_macros.svh
// assertion macros shared by the timer queue rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MHTQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define MHTQ_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: hw/rtl/mhtq_pkg.sv
// types, codes and helpers for the min-heap timer queue
// no dependencies
package mhtq_pkg;

  localparam int OPW   = 3;
  localparam int IDW   = 10;
  localparam int TMOW  = 30;
  localparam int ELW   = 16;
  localparam int KINDW = 2;
  localparam int MSW   = 32;

  // opcodes
  localparam logic [OPW-1:0] OP_ADD   = 3'd0;
  localparam logic [OPW-1:0] OP_ADJ   = 3'd1;
  localparam logic [OPW-1:0] OP_FIRE  = 3'd2;
  localparam logic [OPW-1:0] OP_ADV   = 3'd3;
  localparam logic [OPW-1:0] OP_DROP  = 3'd4;
  localparam logic [OPW-1:0] OP_CLEAR = 3'd5;
  localparam logic [OPW-1:0] OP_NEXT  = 3'd6;

  // result kinds
  localparam logic [KINDW-1:0] KIND_FIRED  = 2'd0;
  localparam logic [KINDW-1:0] KIND_REPORT = 2'd1;
  localparam logic [KINDW-1:0] KIND_REJECT = 2'd2;

  localparam logic [TMOW-1:0] WAIT_MAX = 30'h3FFF_FFFF;

  typedef logic [MSW-1:0] ms_t;

  typedef struct packed {
    ms_t            expiry;
    logic [IDW-1:0] owner;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             advance;
    logic             clear;
    logic             map_rd;
    logic             slot_rd;
    logic             cur_new;
    logic             cur_slot;
    logic             rm_start;
    logic             rm_load;
    logic             root_rd;
    logic             root_chk;
    logic             sd_rd;
    logic             sd_best;
    logic             sd_cmp;
    logic             sd_move;
    logic             su_rd;
    logic             su_move;
    logic             fin;
    logic             emit;
    logic             flush;
    logic [KINDW-1:0] kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OPW-1:0] in_op;
    logic [OPW-1:0] op;
    logic           id_ok;
    logic           present;
    logic           full;
    logic           empty;
    logic           slot_lt_last;
    logic           due;
    logic           has_child;
    logic           has_right;
    logic           sd_go;
    logic           moved;
    logic           at_root;
    logic           su_go;
    logic           pend_v;
    logic           out_free;
  } sts_t;

  // wrap-safe time order: a strictly before b
  function automatic logic earlier(ms_t a, ms_t b);
    ms_t d;
    d = a - b;
    return d[MSW-1];
  endfunction

endpackage

// File: hw/rtl/mhtq_if.sv
// valid/ready channel interfaces for the timer queue
// depends on mhtq_pkg
interface mhtq_in_if;
  logic                          valid;
  logic                          ready;
  logic [mhtq_pkg::OPW-1:0]      opcode;
  logic [mhtq_pkg::IDW-1:0]      timer_id;
  logic [mhtq_pkg::TMOW-1:0]     timeout_ms;
  logic [mhtq_pkg::ELW-1:0]      elapsed_ms;

  modport source (output valid, opcode, timer_id, timeout_ms, elapsed_ms, input ready);
  modport sink   (input valid, opcode, timer_id, timeout_ms, elapsed_ms, output ready);
endinterface

interface mhtq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mhtq_pkg::KINDW-1:0]    kind;
  logic [mhtq_pkg::IDW-1:0]      fired_id;
  logic [mhtq_pkg::TMOW-1:0]     wait_ms;
  logic                          queue_empty;
  logic                          last;

  modport source (output valid, kind, fired_id, wait_ms, queue_empty, last, input ready);
  modport sink   (input valid, kind, fired_id, wait_ms, queue_empty, last, output ready);
endinterface

// File: hw/rtl/mhtq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/mhtq_dp.sv
// datapath of the timer queue: heap and id map rams, clock, sift registers, result stage
// depends on mhtq_pkg, mhtq_ram and assert_macros.svh
`include "assert_macros.svh"

module mhtq_dp #(
  parameter int CAPACITY = 32,
  parameter int ID_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mhtq_pkg::cmd_t                cmd,
  output mhtq_pkg::sts_t                sts,
  input  logic [mhtq_pkg::OPW-1:0]      in_opcode,
  input  logic [mhtq_pkg::IDW-1:0]      in_timer_id,
  input  logic [mhtq_pkg::TMOW-1:0]     in_timeout_ms,
  input  logic [mhtq_pkg::ELW-1:0]      in_elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mhtq_pkg::KINDW-1:0]    out_kind,
  output logic [mhtq_pkg::IDW-1:0]      out_fired_id,
  output logic [mhtq_pkg::TMOW-1:0]     out_wait_ms,
  output logic                          out_queue_empty,
  output logic                          out_last
);

  localparam int HAW = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CXW = HAW + 2;
  localparam int MAW = $clog2(ID_COUNT);
  localparam int EW  = $bits(mhtq_pkg::entry_t);

  // item registers
  logic [mhtq_pkg::OPW-1:0]  op_r;
  logic [mhtq_pkg::IDW-1:0]  id_r;
  logic [mhtq_pkg::TMOW-1:0] tmo_r;
  logic [mhtq_pkg::IDW-1:0]  fid_r;
  logic [mhtq_pkg::TMOW-1:0] wait_r;

  // queue state
  mhtq_pkg::ms_t   now_r;
  logic [CW-1:0]   cnt_r;

  // sift registers
  logic [HAW-1:0]  slot_r;
  logic [HAW-1:0]  hole_r;
  logic [HAW-1:0]  bidx_r;
  logic [HAW-1:0]  par_r;
  mhtq_pkg::entry_t cur_r;
  mhtq_pkg::entry_t best_r;
  logic            moved_r;

  // result stage: pending word and output word
  logic                       pend_v_r;
  logic [mhtq_pkg::KINDW-1:0] pend_kind_r;
  logic [mhtq_pkg::IDW-1:0]   pend_id_r;
  logic [mhtq_pkg::TMOW-1:0]  pend_wait_r;
  logic                       pend_empty_r;
  logic                       out_v_r;
  logic [mhtq_pkg::KINDW-1:0] out_kind_r;
  logic [mhtq_pkg::IDW-1:0]   out_id_r;
  logic [mhtq_pkg::TMOW-1:0]  out_wait_r;
  logic                       out_empty_r;
  logic                       out_last_r;

  // ram ports
  logic             heap_we;
  logic [HAW-1:0]   heap_waddr;
  mhtq_pkg::entry_t heap_wdata;
  logic [HAW-1:0]   heap_raddr;
  logic [EW-1:0]    heap_rbits;
  mhtq_pkg::entry_t heap_rd;
  logic             map_we;
  logic [MAW-1:0]   map_waddr;
  logic [HAW-1:0]   map_rdata;

  // derived values
  logic [CXW-1:0]   child;
  logic [CXW-1:0]   right;
  logic [HAW-1:0]   parent;
  mhtq_pkg::ms_t    new_exp;
  mhtq_pkg::ms_t    root_diff;
  logic             root_due;
  logic [mhtq_pkg::TMOW-1:0] root_wait;
  logic             id_ok;
  logic             out_free;
  logic [CW-1:0]    cnt_dec;

  assign heap_rd   = mhtq_pkg::entry_t'(heap_rbits);
  assign child     = (CXW'(hole_r) << 1) | CXW'(1);
  assign right     = child + CXW'(1);
  assign parent    = (hole_r - HAW'(1)) >> 1;
  assign new_exp   = now_r + mhtq_pkg::ms_t'(tmo_r);
  assign root_diff = heap_rd.expiry - now_r;
  assign root_due  = (root_diff == '0) || root_diff[mhtq_pkg::MSW-1];
  assign root_wait = root_diff[mhtq_pkg::MSW-1] ? '0 :
                     (root_diff[mhtq_pkg::MSW-2] ? mhtq_pkg::WAIT_MAX :
                      root_diff[mhtq_pkg::TMOW-1:0]);
  assign id_ok     = 32'(id_r) < 32'(ID_COUNT);
  assign out_free  = !out_v_r || out_ready;
  assign cnt_dec   = cnt_r - CW'(1);

  // ram address and write data selection
  always_comb begin
    heap_raddr = '0;
    if (cmd.slot_rd) begin
      heap_raddr = map_rdata;
    end else if (cmd.rm_start) begin
      heap_raddr = HAW'(cnt_dec);
    end else if (cmd.sd_rd) begin
      heap_raddr = HAW'(child);
    end else if (cmd.sd_best) begin
      heap_raddr = HAW'(right);
    end else if (cmd.su_rd) begin
      heap_raddr = parent;
    end
  end

  always_comb begin
    heap_we    = cmd.sd_move || cmd.su_move || cmd.fin;
    heap_waddr = hole_r;
    heap_wdata = cur_r;
    if (cmd.sd_move) begin
      heap_wdata = best_r;
    end else if (cmd.su_move) begin
      heap_wdata = heap_rd;
    end
    map_we    = heap_we;
    map_waddr = MAW'(heap_wdata.owner);
  end

  mhtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk  (clk),
    .we   (heap_we),
    .waddr(heap_waddr),
    .wdata(heap_wdata),
    .raddr(heap_raddr),
    .rdata(heap_rbits)
  );

  // id to slot map; an entry counts only when the heap slot points back at the id
  mhtq_ram #(.WIDTH(HAW), .DEPTH(ID_COUNT)) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(heap_waddr),
    .raddr(MAW'(id_r)),
    .rdata(map_rdata)
  );

  // clock, count and result valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load && cmd.advance) begin
        now_r <= now_r + mhtq_pkg::ms_t'(in_elapsed_ms);
      end
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.cur_new) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.rm_start) begin
        cnt_r <= cnt_dec;
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if ((cmd.emit && pend_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // item, sift and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      id_r   <= in_timer_id;
      tmo_r  <= in_timeout_ms;
      fid_r  <= in_timer_id;
      slot_r <= '0;
    end
    if (cmd.slot_rd) begin
      slot_r <= map_rdata;
    end
    if (cmd.root_rd) begin
      slot_r <= '0;
      wait_r <= '0;
    end
    if (cmd.root_chk) begin
      fid_r  <= heap_rd.owner;
      wait_r <= root_wait;
    end
    if (cmd.cur_new || cmd.cur_slot) begin
      cur_r.expiry <= new_exp;
      cur_r.owner  <= id_r;
      hole_r       <= cmd.cur_new ? HAW'(cnt_r) : slot_r;
      moved_r      <= 1'b0;
    end
    if (cmd.rm_load) begin
      cur_r   <= heap_rd;
      hole_r  <= slot_r;
      moved_r <= 1'b0;
    end
    if (cmd.sd_best) begin
      best_r <= heap_rd;
      bidx_r <= HAW'(child);
    end
    if (cmd.sd_cmp && mhtq_pkg::earlier(heap_rd.expiry, best_r.expiry)) begin
      best_r <= heap_rd;
      bidx_r <= HAW'(right);
    end
    if (cmd.sd_move) begin
      hole_r  <= bidx_r;
      moved_r <= 1'b1;
    end
    if (cmd.su_rd) begin
      par_r <= parent;
    end
    if (cmd.su_move) begin
      hole_r <= par_r;
    end
    if (cmd.emit) begin
      pend_kind_r  <= cmd.kind;
      pend_id_r    <= (cmd.kind == mhtq_pkg::KIND_REPORT) ? '0 : fid_r;
      pend_wait_r  <= (cmd.kind == mhtq_pkg::KIND_REPORT) ? wait_r : '0;
      pend_empty_r <= (cnt_r == '0);
    end
    if ((cmd.emit && pend_v_r) || cmd.flush) begin
      out_kind_r  <= pend_kind_r;
      out_id_r    <= pend_id_r;
      out_wait_r  <= pend_wait_r;
      out_empty_r <= pend_empty_r;
      out_last_r  <= cmd.flush;
    end
  end

  // status to the controller
  always_comb begin
    sts.in_op        = in_opcode;
    sts.op           = op_r;
    sts.id_ok        = id_ok;
    sts.present      = id_ok && (CW'(slot_r) < cnt_r) && (heap_rd.owner == id_r);
    sts.full         = cnt_r >= CW'(CAPACITY);
    sts.empty        = (cnt_r == '0);
    sts.slot_lt_last = CW'(slot_r) < cnt_dec;
    sts.due          = root_due;
    sts.has_child    = child < CXW'(cnt_r);
    sts.has_right    = right < CXW'(cnt_r);
    sts.sd_go        = mhtq_pkg::earlier(best_r.expiry, cur_r.expiry);
    sts.moved        = moved_r;
    sts.at_root      = (hole_r == '0);
    sts.su_go        = mhtq_pkg::earlier(cur_r.expiry, heap_rd.expiry);
    sts.pend_v       = pend_v_r;
    sts.out_free     = out_free;
  end

  assign out_valid       = out_v_r;
  assign out_kind        = out_kind_r;
  assign out_fired_id    = out_id_r;
  assign out_wait_ms     = out_wait_r;
  assign out_queue_empty = out_empty_r;
  assign out_last        = out_last_r;

  `MHTQ_ASSERT(a_cnt_bound, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  `MHTQ_ASSERT_IMP(a_wr_in_heap, heap_we, CW'(hole_r) < cnt_r, "heap write outside live slots")
  `MHTQ_ASSERT_IMP(a_no_overrun, (cmd.emit && pend_v_r) || cmd.flush, out_free, "result overwritten")

endmodule

// File: hw/rtl/mhtq_ctrl.sv
// controller state machine of the timer queue: sequences lookup, removal, sift and results
// depends on mhtq_pkg and assert_macros.svh
`include "assert_macros.svh"

module mhtq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output mhtq_pkg::cmd_t cmd,
  input  mhtq_pkg::sts_t sts
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LK0   = 5'd1;
  localparam logic [4:0] S_LK1   = 5'd2;
  localparam logic [4:0] S_LK2   = 5'd3;
  localparam logic [4:0] S_RM0   = 5'd4;
  localparam logic [4:0] S_RM1   = 5'd5;
  localparam logic [4:0] S_SD0   = 5'd6;
  localparam logic [4:0] S_SD1   = 5'd7;
  localparam logic [4:0] S_SD2   = 5'd8;
  localparam logic [4:0] S_SD3   = 5'd9;
  localparam logic [4:0] S_SU0   = 5'd10;
  localparam logic [4:0] S_SU1   = 5'd11;
  localparam logic [4:0] S_FIN   = 5'd12;
  localparam logic [4:0] S_EMIT  = 5'd13;
  localparam logic [4:0] S_DUE0  = 5'd14;
  localparam logic [4:0] S_DUE1  = 5'd15;
  localparam logic [4:0] S_FLUSH = 5'd16;

  logic [4:0]                 state_r, state_nxt;
  logic [mhtq_pkg::KINDW-1:0] kind_r, kind_nxt;
  logic                       rm_word;

  // a removal for fire now, advance or next wait reports the fired id
  assign rm_word = (sts.op == mhtq_pkg::OP_FIRE) || (sts.op == mhtq_pkg::OP_ADV) ||
                   (sts.op == mhtq_pkg::OP_NEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= mhtq_pkg::KIND_FIRED;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.advance = (sts.in_op == mhtq_pkg::OP_ADV);
          case (sts.in_op)
            mhtq_pkg::OP_ADD, mhtq_pkg::OP_ADJ, mhtq_pkg::OP_FIRE: state_nxt = S_LK0;
            mhtq_pkg::OP_ADV, mhtq_pkg::OP_NEXT: state_nxt = S_DUE0;
            mhtq_pkg::OP_DROP: state_nxt = sts.empty ? S_FLUSH : S_RM0;
            mhtq_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_FLUSH;
            end
            default: state_nxt = S_FLUSH;
          endcase
        end
      end
      S_LK0: begin
        cmd.map_rd = 1'b1;
        state_nxt  = S_LK1;
      end
      S_LK1: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_LK2;
      end
      S_LK2: begin
        case (sts.op)
          mhtq_pkg::OP_ADD: begin
            if (sts.present) begin
              cmd.cur_slot = 1'b1;
              state_nxt    = S_SD0;
            end else if (!sts.id_ok || sts.full) begin
              kind_nxt  = mhtq_pkg::KIND_REJECT;
              state_nxt = S_EMIT;
            end else begin
              cmd.cur_new = 1'b1;
              state_nxt   = S_SD0;
            end
          end
          mhtq_pkg::OP_ADJ: begin
            if (sts.present) begin
              cmd.cur_slot = 1'b1;
              state_nxt    = S_SD0;
            end else begin
              kind_nxt  = mhtq_pkg::KIND_REJECT;
              state_nxt = S_EMIT;
            end
          end
          default: begin
            if (sts.present) begin
              state_nxt = S_RM0;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
        endcase
      end
      S_RM0: begin
        cmd.rm_start = 1'b1;
        if (sts.slot_lt_last) begin
          state_nxt = S_RM1;
        end else if (rm_word) begin
          kind_nxt  = mhtq_pkg::KIND_FIRED;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_RM1: begin
        cmd.rm_load = 1'b1;
        state_nxt   = S_SD0;
      end
      // sift down: read children, pick the earlier, move it up into the hole
      S_SD0: begin
        if (sts.has_child) begin
          cmd.sd_rd = 1'b1;
          state_nxt = S_SD1;
        end else begin
          state_nxt = sts.moved ? S_FIN : S_SU0;
        end
      end
      S_SD1: begin
        cmd.sd_best = 1'b1;
        state_nxt   = sts.has_right ? S_SD2 : S_SD3;
      end
      S_SD2: begin
        cmd.sd_cmp = 1'b1;
        state_nxt  = S_SD3;
      end
      S_SD3: begin
        if (sts.sd_go) begin
          cmd.sd_move = 1'b1;
          state_nxt   = S_SD0;
        end else begin
          state_nxt = sts.moved ? S_FIN : S_SU0;
        end
      end
      // sift up: pull later parents down into the hole
      S_SU0: begin
        if (sts.at_root) begin
          state_nxt = S_FIN;
        end else begin
          cmd.su_rd = 1'b1;
          state_nxt = S_SU1;
        end
      end
      S_SU1: begin
        if (sts.su_go) begin
          cmd.su_move = 1'b1;
          state_nxt   = S_SU0;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (rm_word && (sts.op != mhtq_pkg::OP_ADD) && (sts.op != mhtq_pkg::OP_ADJ)) begin
          kind_nxt  = mhtq_pkg::KIND_FIRED;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_EMIT: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.emit = 1'b1;
          if ((kind_r == mhtq_pkg::KIND_FIRED) &&
              ((sts.op == mhtq_pkg::OP_ADV) || (sts.op == mhtq_pkg::OP_NEXT))) begin
            state_nxt = S_DUE0;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      // due check on the root entry
      S_DUE0: begin
        cmd.root_rd = 1'b1;
        if (!sts.empty) begin
          state_nxt = S_DUE1;
        end else if (sts.op == mhtq_pkg::OP_NEXT) begin
          kind_nxt  = mhtq_pkg::KIND_REPORT;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_DUE1: begin
        cmd.root_chk = 1'b1;
        if (sts.due) begin
          state_nxt = S_RM0;
        end else if (sts.op == mhtq_pkg::OP_NEXT) begin
          kind_nxt  = mhtq_pkg::KIND_REPORT;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `MHTQ_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !sts.pend_v, "word left pending at idle")

endmodule

// File: hw/rtl/min_heap_timer_queue_core.sv
// top level of the min-heap timer queue: controller, datapath and channel wiring
// depends on mhtq_pkg, mhtq_if, mhtq_ctrl and mhtq_dp
//
//  channel   dir  fields                                          handshake
//  in_chan   in   opcode timer_id timeout_ms elapsed_ms           valid/ready
//  out_chan  out  kind fired_id wait_ms queue_empty last          valid/ready
//
// one item at a time: accept, lookup, removal, each sift-down level, each sift-up level,
// a write-back, the result words and a finish; clear, unknown opcodes and a drop on an
// empty queue go straight from accept to the finish. advance and next wait repeat the
// due check and removal for every fired entry. a stalled receiver holds words in the
// pending and output registers; the last word of an item sits there while the next
// item is taken. reset clears the count, clock, result valid flags and controller state;
// the id map needs no clearing pass, since an id counts as present only when its slot
// is live and points back at the same id.
module min_heap_timer_queue_core #(
  parameter int CAPACITY = 32,
  parameter int ID_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  mhtq_in_if.sink    in_chan,
  mhtq_out_if.source out_chan
);

  mhtq_pkg::cmd_t cmd;
  mhtq_pkg::sts_t sts;

  mhtq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  mhtq_dp #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_chan.opcode),
    .in_timer_id    (in_chan.timer_id),
    .in_timeout_ms  (in_chan.timeout_ms),
    .in_elapsed_ms  (in_chan.elapsed_ms),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_kind       (out_chan.kind),
    .out_fired_id   (out_chan.fired_id),
    .out_wait_ms    (out_chan.wait_ms),
    .out_queue_empty(out_chan.queue_empty),
    .out_last       (out_chan.last)
  );

endmodule
